@@ design/sha256_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// SHA-256 stream hasher package
// Shared types, constants and round functions for the SHA-256 hasher.
// ============================================================================
package sha256_pkg;

    localparam int BLOCK_BYTES = 64;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef logic [31:0] word_t;

    localparam word_t INIT_HASH [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam word_t ROUND_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    function automatic word_t rotr(input word_t v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t big_sigma0(input word_t v);
        big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t v);
        big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t v);
        small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t v);
        small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

@@ design/sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// ============================================================================
// SHA-256 stream hasher
// Byte-serial SHA-256 with one shared round unit under a small sequencer.
// ============================================================================
// Usage: requests arrive on the input channel (valid/ready) with a kind and a
// data byte. A start request reloads the initial hash and clears the counts.
// A data request appends one byte; the 64th byte of a block also starts the
// compression: the schedule words are loaded from the block store one byte
// at a time, then the rounds run on the single round unit, and then comes
// the chaining add. The load goes byte by byte as the store port is one byte
// wide. A finish request writes the 0x80 marker, then the padding one byte
// per cycle up to the end of the block, and runs a compression; when more
// than 55 bytes are held, a second block of padding and a second compression
// follow. It then emits eight digest words on the output channel, word 0
// first, with last_word on the eighth; each word is first loaded into the
// output register and then handed over. Input ready is low while any of
// this work is under way. When the receiver stalls, the word holds until
// taken and the block waits. Reset acts as a start request.
// Kind 3 is accepted and ignored.
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic        last_word
);
    import sha256_pkg::*;

    localparam int AW = $clog2(BLOCK_BYTES);

    state_t state_reg, state_next;

    // Block store: one byte written, one byte read per cycle.
    logic [7:0] block_mem [BLOCK_BYTES];
    logic [7:0] rd_byte_reg;

    word_t      hash_reg [8];
    word_t      var_reg [8];
    word_t      sched_reg [16];
    logic [AW-1:0] fill_reg;
    logic [60:0] total_reg;
    logic [5:0] round_reg;
    logic [AW:0] load_reg;     // byte address count for the schedule load
    logic       final_reg;     // compression belongs to a finish request
    logic       len_reg;       // padding already holds the length field
    logic [2:0] emit_reg;
    logic       out_valid_reg;
    word_t      out_word_reg;
    logic       out_last_reg;

    logic       wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [AW:0] load_prev;    // address of the byte now in rd_byte_reg
    logic [63:0] bit_len;
    logic       accept;

    word_t w_cur, t1, t2;

    assign accept = in_valid && in_ready;
    assign bit_len = {total_reg, 3'b000};
    assign load_prev = load_reg - 1'b1;
    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign digest_word = out_word_reg;
    assign last_word = out_last_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == KIND_DATA && fill_reg == AW'(BLOCK_BYTES - 1))
                    state_next = ST_LOAD;
                else if (accept && kind == KIND_FINISH)
                begin
                    // A marker in the last byte fills the block at once.
                    if (fill_reg == AW'(BLOCK_BYTES - 1))
                        state_next = ST_LOAD;
                    else
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                if (fill_reg == AW'(BLOCK_BYTES - 1))
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (load_reg == (AW+1)'(BLOCK_BYTES))
                    state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (!final_reg)
                    state_next = ST_IDLE;
                else if (len_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_PAD;
            end
            ST_EMIT:
            begin
                if (out_ready && emit_reg == 3'd7 && out_valid_reg)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Block store write port and read address.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg;
        wr_data = data_byte;
        rd_addr = load_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                wr_en = accept && (kind == KIND_DATA || kind == KIND_FINISH);
                if (kind == KIND_FINISH)
                    wr_data = PAD_MARKER;
            end
            ST_PAD:
            begin
                wr_en = 1'b1;
                if (fill_reg >= AW'(BLOCK_BYTES - 8) && len_reg)
                    wr_data = bit_len[8*(7 - 32'(fill_reg[2:0])) +: 8];
                else
                    wr_data = 8'h00;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            block_mem[wr_addr] <= wr_data;
        rd_byte_reg <= block_mem[rd_addr];
    end

    // Round unit.
    always_comb
    begin
        if (round_reg < 6'd16)
            w_cur = sched_reg[round_reg[3:0]];
        else
            w_cur = small_sigma1(sched_reg[4'(round_reg - 6'd2)])
                  + sched_reg[4'(round_reg - 6'd7)]
                  + small_sigma0(sched_reg[4'(round_reg - 6'd15)])
                  + sched_reg[round_reg[3:0]];
        t1 = var_reg[7] + big_sigma1(var_reg[4])
           + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
           + ROUND_K[round_reg] + w_cur;
        t2 = big_sigma0(var_reg[0])
           + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            total_reg     <= '0;
            round_reg     <= '0;
            load_reg      <= '0;
            final_reg     <= 1'b0;
            len_reg       <= 1'b0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                hash_reg[i] <= INIT_HASH[i];
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && kind == KIND_START)
                    begin
                        fill_reg  <= '0;
                        total_reg <= '0;
                        for (int i = 0; i < 8; i++)
                            hash_reg[i] <= INIT_HASH[i];
                    end
                    else if (accept && kind == KIND_DATA)
                    begin
                        fill_reg  <= fill_reg + 1'b1;
                        total_reg <= total_reg + 61'd1;
                        final_reg <= 1'b0;
                        load_reg  <= '0;
                    end
                    else if (accept && kind == KIND_FINISH)
                    begin
                        // The 0x80 marker goes in here; PAD fills the rest.
                        final_reg <= 1'b1;
                        len_reg   <= (fill_reg < AW'(BLOCK_BYTES - 8));
                        fill_reg  <= fill_reg + 1'b1;
                        load_reg  <= '0;
                    end
                end
                ST_PAD:
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                ST_LOAD:
                begin
                    // Read data comes from a registered read port, so it belongs to load_prev.
                    load_reg <= load_reg + 1'b1;
                    if (load_reg != '0)
                        sched_reg[load_prev[AW-1:2]][8*(3 - 32'(load_prev[1:0])) +: 8]
                            <= rd_byte_reg;
                    round_reg <= '0;
                    for (int i = 0; i < 8; i++)
                        var_reg[i] <= hash_reg[i];
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 1'b1;
                    if (round_reg >= 6'd16)
                        sched_reg[round_reg[3:0]] <= w_cur;
                    var_reg[7] <= var_reg[6];
                    var_reg[6] <= var_reg[5];
                    var_reg[5] <= var_reg[4];
                    var_reg[4] <= var_reg[3] + t1;
                    var_reg[3] <= var_reg[2];
                    var_reg[2] <= var_reg[1];
                    var_reg[1] <= var_reg[0];
                    var_reg[0] <= t1 + t2;
                end
                ST_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        hash_reg[i] <= hash_reg[i] + var_reg[i];
                    load_reg <= '0;
                    emit_reg <= '0;
                    fill_reg <= '0;
                    len_reg  <= 1'b1;
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_word_reg  <= hash_reg[emit_reg];
                        out_last_reg  <= (emit_reg == 3'd7);
                    end
                    else if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        emit_reg      <= emit_reg + 1'b1;
                        if (emit_reg == 3'd7)
                        begin
                            fill_reg  <= '0;
                            total_reg <= '0;
                            for (int i = 0; i < 8; i++)
                                hash_reg[i] <= INIT_HASH[i];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready) else $error("ready while busy");
    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == ST_EMIT)) else $error("output outside emit");
    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && state_next == ST_ROUND) |=> (round_reg == 6'd0))
        else $error("round count not cleared");
`endif

endmodule

@@ bench/tb_sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// ============================================================================
// SHA-256 stream hasher testbench
// Drives start, data, finish and unused-kind requests with random idle gaps on
// both channels, predicts each digest with a behavioral SHA-256 and compares
// every emitted digest word and its last flag in order.
// ============================================================================
module tb_sha256_stream_hasher;

    import sha256_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic        last_word;

    sha256_stream_hasher u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .last_word   (last_word)
    );

    // One pending request. A drain marker makes the driver hold off until
    // every expected digest word has been taken.
    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        bit         drain;
    } request_t;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } digest_item_t;

    request_t     pending_requests[$];
    digest_item_t expected_words[$];

    // Predictor state: chaining hash, partial block and message length.
    logic [31:0] hash_state[8];
    logic [7:0]  block_bytes[64];
    int unsigned block_fill;
    logic [60:0] message_bytes;

    int  error_count;
    int  cycle_count;
    int  requests_sent;
    int  digests_seen;
    bit  stimulus_done;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // One SHA-256 compression of block_bytes into hash_state.
    task automatic compress_block();
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int r = 0; r < 64; r++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[r] + w[r];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic begin_message();
        for (int i = 0; i < 8; i++)
            hash_state[i] = INIT_HASH[i];
        block_fill = 0;
        message_bytes = '0;
    endtask

    // Advances the predictor by one accepted request and queues the digest
    // words that a finish request produces.
    task automatic predict_request(input logic [1:0] k, input logic [7:0] d);
        logic [63:0]  bit_length;
        int unsigned  n;
        digest_item_t item;
        if (k == KIND_START)
            begin_message();
        else if (k == KIND_DATA)
        begin
            block_bytes[block_fill] = d;
            message_bytes = message_bytes + 61'd1;
            block_fill++;
            if (block_fill == 64)
            begin
                compress_block();
                block_fill = 0;
            end
        end
        else if (k == KIND_FINISH)
        begin
            bit_length = {message_bytes, 3'b000};
            n = block_fill;
            block_bytes[n] = 8'h80;
            n++;
            if (n > 56)
            begin
                while (n < 64)
                begin
                    block_bytes[n] = 8'h00;
                    n++;
                end
                compress_block();
                n = 0;
            end
            while (n < 56)
            begin
                block_bytes[n] = 8'h00;
                n++;
            end
            for (int i = 0; i < 8; i++)
                block_bytes[63 - i] = bit_length[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                item.word = hash_state[i];
                item.last = (i == 7);
                expected_words.push_back(item);
            end
            begin_message();
        end
    endtask

    function automatic request_t make_request(input logic [1:0] k, input logic [7:0] d);
        request_t r;
        r.kind = k;
        r.data = d;
        r.drain = 1'b0;
        return r;
    endfunction

    task automatic queue_message(input int length);
        pending_requests.push_back(make_request(KIND_START, 8'h00));
        for (int i = 0; i < length; i++)
            pending_requests.push_back(make_request(KIND_DATA, 8'($urandom)));
        pending_requests.push_back(make_request(KIND_FINISH, 8'($urandom)));
    endtask

    // Stimulus plan: directed cases first, then mostly well-formed messages
    // with random content, spiced with stray unused kinds and restarts.
    initial
    begin
        request_t r;
        int       len;
        begin_message();
        // Empty message straight out of reset, then a finish right after a
        // finish, which must again give the empty-message digest.
        pending_requests.push_back(make_request(KIND_FINISH, 8'hFF));
        pending_requests.push_back(make_request(KIND_FINISH, 8'h00));
        // Unused kind in the middle of a message must change nothing.
        pending_requests.push_back(make_request(KIND_DATA, 8'h00));
        pending_requests.push_back(make_request(KIND_UNUSED, 8'hA5));
        pending_requests.push_back(make_request(KIND_DATA, 8'hFF));
        pending_requests.push_back(make_request(KIND_DATA, 8'h55));
        pending_requests.push_back(make_request(KIND_DATA, 8'hAA));
        // A start in the middle of a message discards the bytes so far.
        pending_requests.push_back(make_request(KIND_START, 8'h12));
        pending_requests.push_back(make_request(KIND_DATA, 8'h61));
        pending_requests.push_back(make_request(KIND_DATA, 8'h62));
        pending_requests.push_back(make_request(KIND_DATA, 8'h63));
        pending_requests.push_back(make_request(KIND_FINISH, 8'h00));
        r = make_request(KIND_START, 8'h00);
        r.drain = 1'b1;
        pending_requests.push_back(r);

        // Padding boundaries: 55 fits one block, 56 needs an extra one,
        // 63 and 64 sit at the block edge.
        queue_message(55);
        queue_message(56);
        queue_message(63);
        queue_message(64);
        queue_message(0);
        while (pending_requests.size() < 360)
        begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(50, 70);
                1: len = $urandom_range(0, 3);
                2: pending_requests.push_back(make_request(KIND_UNUSED, 8'($urandom)));
                default: len = $urandom_range(0, 40);
            endcase
            if (pending_requests.size() + len > 366)
                len = (pending_requests.size() < 366) ? 366 - pending_requests.size() : 0;
            if ($urandom_range(0, 7) == 0)
            begin
                // Broken sequence: a byte, an unused kind and a restart.
                pending_requests.push_back(make_request(KIND_DATA, 8'($urandom)));
                pending_requests.push_back(make_request(KIND_UNUSED, 8'($urandom)));
            end
            queue_message(len);
            if ($urandom_range(0, 15) == 0)
            begin
                r = make_request(KIND_START, 8'h00);
                r.drain = 1'b1;
                pending_requests.push_back(r);
            end
        end
    end

    // Driver: presents requests with random gaps, holding a request stable
    // until it is accepted.
    int  send_gap;
    bit  drain_wait;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            kind      <= KIND_START;
            data_byte <= 8'h00;
            send_gap  <= $urandom_range(0, 4);
            drain_wait <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_request(kind, data_byte);
                requests_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (drain_wait)
                begin
                    in_valid <= 1'b0;
                    if (expected_words.size() == 0 && !(in_valid && in_ready
                        && kind == KIND_FINISH))
                        drain_wait <= 1'b0;
                end
                else if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_requests.size() > 0)
                begin
                    if (pending_requests[0].drain)
                    begin
                        pending_requests[0].drain = 1'b0;
                        drain_wait <= 1'b1;
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        in_valid  <= 1'b1;
                        kind      <= pending_requests[0].kind;
                        data_byte <= pending_requests[0].data;
                        void'(pending_requests.pop_front());
                        send_gap  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                    stimulus_done <= 1'b1;
                end
            end
        end
    end

    // Monitor: takes digest words with random stalls and checks each one
    // against the oldest expected word.
    int recv_gap;
    digest_item_t expected_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= $urandom_range(0, 4);
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("digest_word 0x%08h arrived with nothing expected", digest_word);
                    error_count++;
                end
                else
                begin
                    expected_item = expected_words.pop_front();
                    if (digest_word !== expected_item.word)
                    begin
                        $error("digest_word: expected 0x%08h, got 0x%08h",
                               expected_item.word, digest_word);
                        error_count++;
                    end
                    if (last_word !== expected_item.last)
                    begin
                        $error("last_word: expected %0d, got %0d",
                               expected_item.last, last_word);
                        error_count++;
                    end
                    if (expected_item.last)
                        digests_seen++;
                end
                recv_gap <= (cycle_count % 3000 < 600) ? 0 : $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Run control: reset once, then wait for the stimulus and the results to
    // drain, with a cycle limit as a backstop.
    initial
    begin
        rst_n = 1'b0;
        error_count = 0;
        cycle_count = 0;
        requests_sent = 0;
        digests_seen = 0;
        stimulus_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        while (!(stimulus_done && expected_words.size() == 0)
               && cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
        end
        else
        begin
            // Let the block settle after the last word before the summary.
            repeat (300) @(posedge clk);
            $display("Sent %0d requests, checked %0d digests (padding edges, restarts,",
                     requests_sent, digests_seen);
            $display("unused kinds and block-crossing messages included).");
            if (error_count == 0 && expected_words.size() == 0)
                $display("Testbench completed without errors");
            else
                $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
